FILE: rtl/core/ubfg_pkg.sv
`default_nettype none

package ubfg_pkg;

   // Field and register widths.
   localparam int POS_W      = 31;
   localparam int SIZE_W     = 7;
   localparam int STEP_W     = 16;
   localparam int COUNT_W    = 17;
   localparam int STRIDE_W   = 31;
   localparam int FOLD_W     = 16;
   localparam int OFF_W      = 6;
   localparam int ELEM_W     = 48;
   localparam int PROD_W     = FOLD_W + STRIDE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   // Divider iteration counts: a full position, and a window-sized dividend.
   localparam int ITER_W = 5;
   localparam logic [ITER_W-1:0] LONG_ITERS  = ITER_W'(POS_W);
   localparam logic [ITER_W-1:0] SHORT_ITERS = ITER_W'(OFF_W);

   localparam logic [SIZE_W-1:0]  MAX_WINDOW = 7'd64;
   localparam logic [COUNT_W-1:0] MAX_FOLDS  = 17'd65536;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_STEP   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FOLD_STRIDE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_STRIDE = 3'd4;

   typedef enum logic [1:0] {
      MUL_KK_STEP,
      MUL_LEFT_FS,
      MUL_OFF_WS,
      MUL_STEP_WS
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_OFF,
      ACC_ELEM_SET,
      ACC_ELEM_ADD,
      ACC_DELTA
   } acc_op_type;

   typedef struct packed {
      logic        load;
      logic        take_q;
      logic        start_short;
      logic        take_k;
      logic        set_fold;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        emit;
      logic        emit_empty;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic miss_range;
      logic miss_left;
      logic at_last;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/ubfg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. For a short run the caller places the
// dividend in the top bits, and the run stops after as many iterations as it has bits.
module ubfg_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ubfg_pkg::POS_W-1:0]    dividend,
   input  wire logic [ubfg_pkg::STEP_W-1:0]   divisor,
   input  wire logic [ubfg_pkg::ITER_W-1:0]   iters,
   output logic                               done,
   output logic [ubfg_pkg::POS_W-1:0]         quotient,
   output logic [ubfg_pkg::STEP_W-1:0]        remainder
);
   import ubfg_pkg::*;

   logic                busy_ff;
   logic                done_ff;
   logic [ITER_W-1:0]   cnt_ff;
   logic [POS_W-1:0]    quo_ff;
   logic [STEP_W-1:0]   rem_ff;
   logic [STEP_W-1:0]   div_ff;

   logic [STEP_W:0]     trial;
   logic [STEP_W:0]     diff;
   logic                fits;
   logic [STEP_W-1:0]   rem_in;
   logic [POS_W-1:0]    quo_in;

   always_comb begin
      trial  = {rem_ff, quo_ff[POS_W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
      quo_in = {quo_ff[POS_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= iters;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - ITER_W'(1);
            if (cnt_ff == ITER_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ubfg_dp.sv
`default_nettype none

module ubfg_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ubfg_pkg::cmd_type                 cmd,
   output ubfg_pkg::status_type                   status,
   input  wire logic [ubfg_pkg::POS_W-1:0]        req_position,
   input  wire logic                              csr_we,
   input  wire logic [ubfg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ubfg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                                   rsp_strobe,
   output logic [ubfg_pkg::FOLD_W-1:0]            rsp_fold_index,
   output logic [ubfg_pkg::OFF_W-1:0]             rsp_offset_in_window,
   output logic [ubfg_pkg::ELEM_W-1:0]            rsp_element_offset,
   output logic                                   rsp_no_contribution,
   output logic                                   rsp_last_of_run
);
   import ubfg_pkg::*;

   // Configuration registers.
   logic [SIZE_W-1:0]   size_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic [STRIDE_W-1:0] fold_stride_ff;
   logic [STRIDE_W-1:0] window_stride_ff;

   // Working registers.
   logic [POS_W-1:0]    q_ff;
   logic [STEP_W-1:0]   r_ff;
   logic [FOLD_W-1:0]   right_ff;
   logic [OFF_W-1:0]    kk_ff;
   logic [POS_W-1:0]    left_ff;
   logic [FOLD_W-1:0]   f_ff;
   logic [OFF_W-1:0]    off_ff;
   logic [ELEM_W-1:0]   elem_ff;
   logic [ELEM_W-1:0]   delta_ff;
   logic [PROD_W-1:0]   prod_ff;

   logic                strobe_ff;
   logic [FOLD_W-1:0]   out_fold_ff;
   logic [OFF_W-1:0]    out_off_ff;
   logic [ELEM_W-1:0]   out_elem_ff;
   logic                out_empty_ff;
   logic                out_last_ff;

   logic [SIZE_W-1:0]   size_eff;
   logic [STEP_W-1:0]   step_eff;
   logic [COUNT_W-1:0]  count_eff;
   logic [COUNT_W-1:0]  count_m1;
   logic [SIZE_W-1:0]   short_num;
   logic [OFF_W-1:0]    k_div;
   logic [OFF_W-1:0]    kk_in;
   logic [FOLD_W-1:0]   right_in;
   logic [FOLD_W-1:0]   mul_a;
   logic [STRIDE_W-1:0] mul_b;

   logic                div_start;
   logic [POS_W-1:0]    div_dividend;
   logic [ITER_W-1:0]   div_iters;
   logic                div_done;
   logic [POS_W-1:0]    div_quo;
   logic [STEP_W-1:0]   div_rem;

   // Out-of-range settings are folded into their legal range here.
   always_comb begin
      if (size_ff == '0) begin
         size_eff = SIZE_W'(1);
      end else if (size_ff > MAX_WINDOW) begin
         size_eff = MAX_WINDOW;
      end else begin
         size_eff = size_ff;
      end
      step_eff  = (step_ff == '0) ? STEP_W'(1) : step_ff;
      count_eff = (count_ff > MAX_FOLDS) ? MAX_FOLDS : count_ff;
      count_m1  = count_eff - COUNT_W'(1);
   end

   // The second division counts how many folds below pos/step still cover
   // the position: (size - 1 - remainder) / step.
   always_comb begin
      short_num    = size_eff - SIZE_W'(1) - r_ff[SIZE_W-1:0];
      div_start    = cmd.load | cmd.start_short;
      div_dividend = cmd.load ? req_position
                              : {short_num[OFF_W-1:0], {(POS_W-OFF_W){1'b0}}};
      div_iters    = cmd.load ? LONG_ITERS : SHORT_ITERS;
      k_div        = div_quo[OFF_W-1:0];
      kk_in        = ({{(POS_W-OFF_W){1'b0}}, k_div} > q_ff) ? q_ff[OFF_W-1:0] : k_div;
      right_in     = (div_quo[COUNT_W-1:0] >= count_eff ||
                      div_quo[POS_W-1:COUNT_W] != '0) ? count_m1[FOLD_W-1:0]
                                                      : div_quo[FOLD_W-1:0];
   end

   ubfg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (step_eff),
      .iters     (div_iters),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      case (cmd.mul_sel)
         MUL_KK_STEP: begin
            mul_a = {{(FOLD_W-OFF_W){1'b0}}, kk_ff};
            mul_b = {{(STRIDE_W-STEP_W){1'b0}}, step_eff};
         end
         MUL_LEFT_FS: begin
            mul_a = f_ff;
            mul_b = fold_stride_ff;
         end
         MUL_OFF_WS: begin
            mul_a = {{(FOLD_W-OFF_W){1'b0}}, off_ff};
            mul_b = window_stride_ff;
         end
         MUL_STEP_WS: begin
            mul_a = step_eff;
            mul_b = window_stride_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      status.div_done   = div_done;
      status.miss_range = (count_eff == '0) ||
                          ({{(STEP_W-SIZE_W){1'b0}}, size_eff} <= r_ff);
      status.miss_left  = (left_ff > {{(POS_W-FOLD_W){1'b0}}, right_ff});
      status.at_last    = (f_ff == right_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff          <= SIZE_W'(1);
         step_ff          <= STEP_W'(1);
         count_ff         <= COUNT_W'(1);
         fold_stride_ff   <= '0;
         window_stride_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SIZE:   size_ff          <= csr_wdata[SIZE_W-1:0];
            CSR_WINDOW_STEP:   step_ff          <= csr_wdata[STEP_W-1:0];
            CSR_FOLD_COUNT:    count_ff         <= csr_wdata[COUNT_W-1:0];
            CSR_FOLD_STRIDE:   fold_stride_ff   <= csr_wdata[STRIDE_W-1:0];
            CSR_WINDOW_STRIDE: window_stride_ff <= csr_wdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit | cmd.emit_empty;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;

      if (cmd.take_q) begin
         q_ff     <= div_quo;
         r_ff     <= div_rem;
         right_ff <= right_in;
      end
      if (cmd.take_k) begin
         kk_ff   <= kk_in;
         left_ff <= q_ff - {{(POS_W-OFF_W){1'b0}}, kk_in};
      end

      if (cmd.set_fold) begin
         f_ff <= left_ff[FOLD_W-1:0];
      end else if (cmd.emit) begin
         f_ff <= f_ff + FOLD_W'(1);
      end

      // Each later fold sits one step further left inside its window.
      if (cmd.acc_op == ACC_OFF) begin
         off_ff <= r_ff[OFF_W-1:0] + prod_ff[OFF_W-1:0];
      end else if (cmd.emit) begin
         off_ff <= off_ff - step_eff[OFF_W-1:0];
      end

      if (cmd.acc_op == ACC_ELEM_SET) begin
         elem_ff <= {1'b0, prod_ff};
      end else if (cmd.acc_op == ACC_ELEM_ADD) begin
         elem_ff <= elem_ff + {1'b0, prod_ff};
      end else if (cmd.emit) begin
         elem_ff <= elem_ff + delta_ff;
      end

      if (cmd.acc_op == ACC_DELTA) begin
         delta_ff <= {{(ELEM_W-STRIDE_W){1'b0}}, fold_stride_ff} - {1'b0, prod_ff};
      end

      if (cmd.emit) begin
         out_fold_ff  <= f_ff;
         out_off_ff   <= off_ff;
         out_elem_ff  <= elem_ff;
         out_empty_ff <= 1'b0;
         out_last_ff  <= status.at_last;
      end else if (cmd.emit_empty) begin
         out_fold_ff  <= '0;
         out_off_ff   <= '0;
         out_elem_ff  <= '0;
         out_empty_ff <= 1'b1;
         out_last_ff  <= 1'b1;
      end
   end

   assign rsp_strobe           = strobe_ff;
   assign rsp_fold_index       = out_fold_ff;
   assign rsp_offset_in_window = out_off_ff;
   assign rsp_element_offset   = out_elem_ff;
   assign rsp_no_contribution  = out_empty_ff;
   assign rsp_last_of_run      = out_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ubfg_ctrl.sv
`default_nettype none

module ubfg_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire ubfg_pkg::status_type    status,
   output ubfg_pkg::cmd_type            cmd
);
   import ubfg_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV1,
      S_RANGE,
      S_DIV2,
      S_CHECK,
      S_M1,
      S_M2,
      S_M3,
      S_M4,
      S_EMIT,
      S_EMPTY
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.mul_sel     = MUL_KK_STEP;
      cmd.acc_op      = ACC_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (status.div_done) begin
               cmd.take_q = 1'b1;
               state_in   = S_RANGE;
            end
         end
         S_RANGE: begin
            if (status.miss_range) begin
               state_in = S_EMPTY;
            end else begin
               cmd.start_short = 1'b1;
               state_in        = S_DIV2;
            end
         end
         S_DIV2: begin
            if (status.div_done) begin
               cmd.take_k = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.set_fold = 1'b1;
            cmd.mul_sel  = MUL_KK_STEP;
            state_in     = status.miss_left ? S_EMPTY : S_M1;
         end
         S_M1: begin
            cmd.acc_op  = ACC_OFF;
            cmd.mul_sel = MUL_LEFT_FS;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.acc_op  = ACC_ELEM_SET;
            cmd.mul_sel = MUL_OFF_WS;
            state_in    = S_M3;
         end
         S_M3: begin
            cmd.acc_op  = ACC_ELEM_ADD;
            cmd.mul_sel = MUL_STEP_WS;
            state_in    = S_M4;
         end
         S_M4: begin
            cmd.acc_op = ACC_DELTA;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (status.at_last) begin
               state_in = S_IDLE;
            end
         end
         S_EMPTY: begin
            cmd.emit_empty = 1'b1;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

FILE: rtl/core/unfold_backward_fold_gather_top.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// req       in         start & !busy           req_position
// rsp       out        rsp_strobe (one cycle)  rsp_fold_index, rsp_offset_in_window,
//                                              rsp_element_offset, rsp_no_contribution,
//                                              rsp_last_of_run
// csr       in         csr_we                  csr_index, csr_wdata
//
// A new item is accepted only after the previous run is over. A run does the two
// divisions and the multiplies, then emits its results one per cycle. The time is
// set by the shared one-bit-per-cycle divider (31 plus 6 iterations) and four
// passes through the single multiplier. An empty run ends at the range or left check.
// Reset is synchronous and active high; it restores the register defaults.
// Results are never held back: the receiver takes each one in its strobe cycle.
module unfold_backward_fold_gather_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [ubfg_pkg::POS_W-1:0]        req_position,
   output logic                                   rsp_strobe,
   output logic [ubfg_pkg::FOLD_W-1:0]            rsp_fold_index,
   output logic [ubfg_pkg::OFF_W-1:0]             rsp_offset_in_window,
   output logic [ubfg_pkg::ELEM_W-1:0]            rsp_element_offset,
   output logic                                   rsp_no_contribution,
   output logic                                   rsp_last_of_run,
   input  wire logic                              csr_we,
   input  wire logic [ubfg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ubfg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ubfg_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       ctrl_busy;
   logic       go;

   assign go   = start & ~ctrl_busy;
   assign busy = ctrl_busy;

   ubfg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (go),
      .busy   (ctrl_busy),
      .status (status),
      .cmd    (cmd)
   );

   ubfg_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_position         (req_position),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .rsp_strobe           (rsp_strobe),
      .rsp_fold_index       (rsp_fold_index),
      .rsp_offset_in_window (rsp_offset_in_window),
      .rsp_element_offset   (rsp_element_offset),
      .rsp_no_contribution  (rsp_no_contribution),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

`default_nettype wire
